/* sv/crqg_pkg.sv */
`default_nettype none

package crqg_pkg;

   // field widths
   localparam int unsigned QuadletWidth = 32;
   localparam int unsigned IndexWidth   = 8;
   localparam int unsigned CrcWidth     = 16;
   localparam int unsigned CsrIndexWidth = 3;

   // rom size in quadlets, reads at or above it give zero
   localparam int unsigned RomQuadlets  = 256;

   // pipeline depth: one crc doublet per stage over the bus info block
   localparam int unsigned NumStages    = 8;
   localparam int unsigned NumDirDoublets = 4;

   // rom constants
   localparam logic [31:0] BusName1394  = 32'h3133_3934;
   localparam logic [15:0] CrcPoly      = 16'h1021;
   localparam logic [5:0]  KeyVendor    = 6'h03;
   localparam logic [5:0]  KeyNodeCaps  = 6'h0C;
   localparam logic [1:0]  EntryImmediate = 2'b00;
   localparam logic [7:0]  BusInfoLength  = 8'h04;
   localparam logic [7:0]  BusInfoCrcLength = 8'h04;

   // rom quadlet positions
   localparam logic [IndexWidth-1:0] QuadBusInfo   = 8'd0;
   localparam logic [IndexWidth-1:0] QuadBusName   = 8'd1;
   localparam logic [IndexWidth-1:0] QuadBusOpts   = 8'd2;
   localparam logic [IndexWidth-1:0] QuadGuidHigh  = 8'd3;
   localparam logic [IndexWidth-1:0] QuadGuidLow   = 8'd4;
   localparam logic [IndexWidth-1:0] QuadRootHdr   = 8'd5;
   localparam logic [IndexWidth-1:0] QuadVendor    = 8'd6;
   localparam logic [IndexWidth-1:0] QuadNodeCaps  = 8'd7;

   // number of built quadlets for each layout
   localparam logic [IndexWidth-1:0] CountBusOnly  = 8'd5;
   localparam logic [IndexWidth-1:0] CountVendor   = 8'd7;
   localparam logic [IndexWidth-1:0] CountNodeCaps = 8'd8;

   // configuration register indexes
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_BUS_OPTIONS      = 3'd0,
      CSR_GUID_HIGH        = 3'd1,
      CSR_GUID_LOW         = 3'd2,
      CSR_ROOT_DIR_ENABLE  = 3'd3,
      CSR_NODE_CAPS_ENABLE = 3'd4
   } csr_index_type;

   // crc of one byte shifted through eight msb-first steps (table entry)
   function automatic logic [CrcWidth-1:0] crc_table(input logic [7:0] b);
      logic [CrcWidth-1:0] c;
      c = {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // one 16-bit doublet folded into the crc, two table lookups
   function automatic logic [CrcWidth-1:0] crc_doublet(input logic [CrcWidth-1:0] crc,
                                                       input logic [CrcWidth-1:0] d);
      logic [CrcWidth-1:0] t;
      logic [CrcWidth-1:0] c;
      t = crc ^ d;
      c = {t[7:0], 8'h00} ^ crc_table(t[15:8]);
      c = {c[7:0], 8'h00} ^ crc_table(c[15:8]);
      return c;
   endfunction

endpackage

`default_nettype wire

/* sv/config_rom_quadlet_generator.sv */
// Configuration ROM quadlet server.
// The req_ stream carries quadlet read requests (req_tdata = quadlet index);
// the rsp_ stream returns one 32-bit quadlet per request, in request order.
// The ROM is built from the csr_ registers: a five-quadlet bus info block
// with its CRC-16, and an optional root directory (vendor entry, optional
// node capabilities entry) with its own CRC. Indexes past the built content
// or at or above ROM_QUADLETS read as zero.
// Pipeline: a request accepted at one clock edge passes through 8 CRC stages
// (one doublet each, the first loaded at the accepting edge), then through
// the output register, before it shows on rsp_tvalid. Throughput: one request
// per cycle while rsp_tready is high.
// Stalls: when rsp_tready is low the output register holds; upstream stages
// keep filling empty slots, and req_tready drops only once every stage holds
// a request. Nothing is lost or repeated.
// Reset (synchronous, active high) empties the pipeline and loads the register
// defaults: register quadlets zero, root directory and node capabilities enabled.
// User rule, unenforced: write registers only while no request is in flight.
`default_nettype none

module config_rom_quadlet_generator #(
   parameter int unsigned ROM_QUADLETS = crqg_pkg::RomQuadlets
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // request stream
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] quadlet_index
   // response stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata,   // [31:0] quadlet_data
   // register write port
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [31:0] csr_wdata
);

   localparam int unsigned NStg = crqg_pkg::NumStages;
   localparam int unsigned NDir = crqg_pkg::NumDirDoublets;

   // configuration registers
   logic [31:0] bus_options_ff;
   logic [31:0] guid_high_ff;
   logic [31:0] guid_low_ff;
   logic        root_dir_enable_ff;
   logic        node_caps_enable_ff;

   // pipeline stages
   logic                                   stg_valid_ff   [NStg];
   logic                                   stg_valid_in   [NStg];
   logic [crqg_pkg::IndexWidth-1:0]        stg_idx_ff     [NStg];
   logic [crqg_pkg::IndexWidth-1:0]        stg_idx_in     [NStg];
   logic [crqg_pkg::CrcWidth-1:0]          stg_bus_crc_ff [NStg];
   logic [crqg_pkg::CrcWidth-1:0]          stg_bus_crc_in [NStg];
   logic [crqg_pkg::CrcWidth-1:0]          stg_dir_crc_ff [NStg];
   logic [crqg_pkg::CrcWidth-1:0]          stg_dir_crc_in [NStg];
   logic                                   stg_open       [NStg+1];

   // output register
   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic [31:0] rsp_data_ff;
   logic [31:0] rsp_data_in;

   // rom content derived from the registers
   logic [31:0] quad_vendor;
   logic [31:0] quad_node_caps;
   logic [crqg_pkg::CrcWidth-1:0] bus_dbl [NStg];
   logic [crqg_pkg::CrcWidth-1:0] dir_dbl [NDir];

   // register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         bus_options_ff      <= '0;
         guid_high_ff        <= '0;
         guid_low_ff         <= '0;
         root_dir_enable_ff  <= 1'b1;
         node_caps_enable_ff <= 1'b1;
      end else if (csr_wr_en) begin
         case (crqg_pkg::csr_index_type'(csr_index))
            crqg_pkg::CSR_BUS_OPTIONS:      bus_options_ff      <= csr_wdata;
            crqg_pkg::CSR_GUID_HIGH:        guid_high_ff        <= csr_wdata;
            crqg_pkg::CSR_GUID_LOW:         guid_low_ff         <= csr_wdata;
            crqg_pkg::CSR_ROOT_DIR_ENABLE:  root_dir_enable_ff  <= csr_wdata[0];
            crqg_pkg::CSR_NODE_CAPS_ENABLE: node_caps_enable_ff <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // directory entries and doublet streams for both crcs
   always_comb begin
      quad_vendor    = {crqg_pkg::EntryImmediate, crqg_pkg::KeyVendor, guid_high_ff[31:8]};
      quad_node_caps = {crqg_pkg::EntryImmediate, crqg_pkg::KeyNodeCaps,
                        bus_options_ff[23:0]};
      bus_dbl[0] = crqg_pkg::BusName1394[31:16];
      bus_dbl[1] = crqg_pkg::BusName1394[15:0];
      bus_dbl[2] = bus_options_ff[31:16];
      bus_dbl[3] = bus_options_ff[15:0];
      bus_dbl[4] = guid_high_ff[31:16];
      bus_dbl[5] = guid_high_ff[15:0];
      bus_dbl[6] = guid_low_ff[31:16];
      bus_dbl[7] = guid_low_ff[15:0];
      dir_dbl[0] = quad_vendor[31:16];
      dir_dbl[1] = quad_vendor[15:0];
      dir_dbl[2] = quad_node_caps[31:16];
      dir_dbl[3] = quad_node_caps[15:0];
   end

   // stage k may load when empty or when stage k+1 takes its request
   always_comb begin
      stg_open[NStg] = !rsp_valid_ff || rsp_tready;
      for (int k = NStg - 1; k >= 0; k--) begin
         stg_open[k] = !stg_valid_ff[k] || stg_open[k+1];
      end
   end

   assign req_tready = stg_open[0];

   // crc stages: each folds one bus info doublet and, early on, one directory doublet
   always_comb begin
      logic                          src_valid;
      logic [crqg_pkg::IndexWidth-1:0] src_idx;
      logic [crqg_pkg::CrcWidth-1:0] src_bus;
      logic [crqg_pkg::CrcWidth-1:0] src_dir;
      src_valid = 1'b0;
      src_idx   = '0;
      src_bus   = '0;
      src_dir   = '0;
      for (int k = 0; k < NStg; k++) begin
         if (k == 0) begin
            src_valid = req_tvalid;
            src_idx   = req_tdata;
            src_bus   = '0;
            src_dir   = '0;
         end else begin
            src_valid = stg_valid_ff[k-1];
            src_idx   = stg_idx_ff[k-1];
            src_bus   = stg_bus_crc_ff[k-1];
            src_dir   = stg_dir_crc_ff[k-1];
         end
         stg_valid_in[k]   = stg_open[k] ? src_valid : stg_valid_ff[k];
         stg_idx_in[k]     = src_idx;
         stg_bus_crc_in[k] = crqg_pkg::crc_doublet(src_bus, bus_dbl[k]);
         // node capabilities entry only covered when enabled
         if (k < 2 || (k < NDir && node_caps_enable_ff)) begin
            stg_dir_crc_in[k] = crqg_pkg::crc_doublet(src_dir, dir_dbl[k % NDir]);
         end else begin
            stg_dir_crc_in[k] = src_dir;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < NStg; k++) begin
         if (reset) begin
            stg_valid_ff[k] <= 1'b0;
         end else begin
            stg_valid_ff[k] <= stg_valid_in[k];
         end
         if (stg_open[k]) begin
            stg_idx_ff[k]     <= stg_idx_in[k];
            stg_bus_crc_ff[k] <= stg_bus_crc_in[k];
            stg_dir_crc_ff[k] <= stg_dir_crc_in[k];
         end
      end
   end

   // quadlet select at the end of the pipe
   always_comb begin
      logic [crqg_pkg::IndexWidth-1:0] count;
      logic [crqg_pkg::IndexWidth-1:0] idx;
      logic [15:0]                     entries;
      logic [31:0]                     quad;
      idx     = stg_idx_ff[NStg-1];
      entries = node_caps_enable_ff ? 16'd2 : 16'd1;
      if (!root_dir_enable_ff) begin
         count = crqg_pkg::CountBusOnly;
      end else if (node_caps_enable_ff) begin
         count = crqg_pkg::CountNodeCaps;
      end else begin
         count = crqg_pkg::CountVendor;
      end
      case (idx)
         crqg_pkg::QuadBusInfo:  quad = {crqg_pkg::BusInfoLength, crqg_pkg::BusInfoCrcLength,
                                         stg_bus_crc_ff[NStg-1]};
         crqg_pkg::QuadBusName:  quad = crqg_pkg::BusName1394;
         crqg_pkg::QuadBusOpts:  quad = bus_options_ff;
         crqg_pkg::QuadGuidHigh: quad = guid_high_ff;
         crqg_pkg::QuadGuidLow:  quad = guid_low_ff;
         crqg_pkg::QuadRootHdr:  quad = {entries, stg_dir_crc_ff[NStg-1]};
         crqg_pkg::QuadVendor:   quad = quad_vendor;
         crqg_pkg::QuadNodeCaps: quad = quad_node_caps;
         default:                quad = '0;
      endcase
      rsp_data_in  = ((idx < count) && (32'(idx) < ROM_QUADLETS)) ? quad : '0;
      rsp_valid_in = stg_open[NStg] ? stg_valid_ff[NStg-1] : rsp_valid_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (stg_open[NStg]) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // an accepted request always lands in the first stage
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stg_valid_ff[0])
      else $error("accepted request missing from first stage");

   // backpressure only when the first stage is occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> stg_valid_ff[0])
      else $error("request stalled with empty first stage");

   // a finished request moves into the output register when it is open
   a_rsp_load: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff[NStg-1] && stg_open[NStg] |=> rsp_valid_ff)
      else $error("finished request dropped before output");

   // reads past the largest layout give zero
   a_past_rom: assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff[NStg-1] && stg_open[NStg] && (stg_idx_ff[NStg-1] > crqg_pkg::QuadNodeCaps)
      |=> rsp_data_ff == '0)
      else $error("nonzero data past built content");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench;

   localparam int IdlePercent    = 11;
   localparam int PhaseCount     = 8;
   localparam int ReadsPerPhase  = 180;
   localparam int HoldOffCycles  = 300;
   localparam int WatchdogLimit  = 2000;
   localparam int SettleCycles   = 20;
   // register indexes the block does not implement
   localparam logic [crqg_pkg::CsrIndexWidth-1:0] CsrFirstUnused = 3'd5;

   typedef struct {
      logic [crqg_pkg::IndexWidth-1:0]   index;
      bit                                fixed;
      logic [crqg_pkg::QuadletWidth-1:0] data;
   } read_row_type;

   typedef struct {
      logic [crqg_pkg::IndexWidth-1:0]   index;
      logic [crqg_pkg::QuadletWidth-1:0] data;
   } quadlet_expect_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en;
   logic [2:0]  csr_index;
   logic [31:0] csr_wdata;

   // shadow copy of the rom registers
   logic [31:0] rom_bus_options;
   logic [31:0] rom_guid_high;
   logic [31:0] rom_guid_low;
   logic        rom_root_dir;
   logic        rom_node_caps;

   quadlet_expect_type quadlet_expect_q[$];
   quadlet_expect_type expected_quadlet;
   int  failures = 0;
   int  stall_cycles = 0;
   bit  quiet = 1'b0;
   bit  hold_off_pending = 1'b0;

   // directed reads under reset defaults: both directory parts enabled, all else zero
   read_row_type directed_rows [16] = '{
      '{8'd0,   1'b0, 32'h0000_0000},
      '{8'd1,   1'b1, 32'h3133_3934},
      '{8'd2,   1'b1, 32'h0000_0000},
      '{8'd3,   1'b1, 32'h0000_0000},
      '{8'd4,   1'b1, 32'h0000_0000},
      '{8'd5,   1'b0, 32'h0000_0000},
      '{8'd6,   1'b1, 32'h0300_0000},
      '{8'd7,   1'b1, 32'h0C00_0000},
      '{8'd8,   1'b1, 32'h0000_0000},
      '{8'd9,   1'b1, 32'h0000_0000},
      '{8'd255, 1'b1, 32'h0000_0000},
      '{8'd128, 1'b1, 32'h0000_0000},
      '{8'h55,  1'b1, 32'h0000_0000},
      '{8'hAA,  1'b1, 32'h0000_0000},
      '{8'd7,   1'b1, 32'h0C00_0000},
      '{8'd0,   1'b0, 32'h0000_0000}
   };

   config_rom_quadlet_generator u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] quadlet_index
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),   // [31:0] quadlet_data
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // crc-16 ccitt, one doublet msb first
   function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [15:0] doublet);
      logic [15:0] c;
      c = crc ^ doublet;
      for (int i = 0; i < 16; i++) begin
         if (c[15]) begin
            c = {c[14:0], 1'b0} ^ crqg_pkg::CrcPoly;
         end else begin
            c = {c[14:0], 1'b0};
         end
      end
      return c;
   endfunction

   // rom image from the shadow registers, one quadlet out
   function automatic logic [31:0] rom_quadlet(input logic [crqg_pkg::IndexWidth-1:0] index);
      logic [31:0] image [8];
      logic [15:0] crc;
      int unsigned built;
      foreach (image[i]) image[i] = '0;
      image[1] = crqg_pkg::BusName1394;
      image[2] = rom_bus_options;
      image[3] = rom_guid_high;
      image[4] = rom_guid_low;
      crc = '0;
      for (int i = 1; i <= 4; i++) begin
         crc = crc_fold(crc, image[i][31:16]);
         crc = crc_fold(crc, image[i][15:0]);
      end
      image[0] = {crqg_pkg::BusInfoLength, crqg_pkg::BusInfoCrcLength, crc};
      built = crqg_pkg::CountBusOnly;
      if (rom_root_dir) begin
         image[6] = {crqg_pkg::EntryImmediate, crqg_pkg::KeyVendor, rom_guid_high[31:8]};
         built = crqg_pkg::CountVendor;
         if (rom_node_caps) begin
            image[7] = {crqg_pkg::EntryImmediate, crqg_pkg::KeyNodeCaps,
                        rom_bus_options[23:0]};
            built = crqg_pkg::CountNodeCaps;
         end
         crc = '0;
         for (int i = 6; i < built; i++) begin
            crc = crc_fold(crc, image[i][31:16]);
            crc = crc_fold(crc, image[i][15:0]);
         end
         image[5] = {16'(built - 6), crc};
      end
      if (index < built) begin
         return image[index[2:0]];
      end
      return '0;
   endfunction

   // offer one read request and record what it must return
   task automatic send_read(input logic [7:0] index, input bit fixed, input logic [31:0] data);
      quadlet_expect_type entry;
      while (!quiet && $urandom_range(99) < IdlePercent) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= index;
      do @(posedge clock); while (!req_tready);
      entry.index = index;
      entry.data  = fixed ? data : rom_quadlet(index);
      quadlet_expect_q = {quadlet_expect_q, entry};
   endtask

   // stop offering until every response is back
   task automatic drain_responses();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (quadlet_expect_q.size() != 0);
   endtask

   task automatic write_register(input logic [2:0] index, input logic [31:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         crqg_pkg::CSR_BUS_OPTIONS:      rom_bus_options = value;
         crqg_pkg::CSR_GUID_HIGH:        rom_guid_high   = value;
         crqg_pkg::CSR_GUID_LOW:         rom_guid_low    = value;
         crqg_pkg::CSR_ROOT_DIR_ENABLE:  rom_root_dir    = value[0];
         crqg_pkg::CSR_NODE_CAPS_ENABLE: rom_node_caps   = value[0];
         default: ;
      endcase
   endtask

   // full register set while idle, then a write to an unused index that must change nothing
   task automatic apply_settings(input logic [31:0] bus_options, input logic [31:0] guid_high,
                                 input logic [31:0] guid_low, input logic [31:0] root_dir,
                                 input logic [31:0] node_caps);
      drain_responses();
      write_register(crqg_pkg::CSR_BUS_OPTIONS, bus_options);
      write_register(crqg_pkg::CSR_GUID_HIGH, guid_high);
      write_register(crqg_pkg::CSR_GUID_LOW, guid_low);
      write_register(crqg_pkg::CSR_ROOT_DIR_ENABLE, root_dir);
      write_register(crqg_pkg::CSR_NODE_CAPS_ENABLE, node_caps);
      write_register(CsrFirstUnused + 3'($urandom_range(2)), $urandom);
      csr_wr_en <= 1'b0;
   endtask

   // receiver: random stalls, one long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         @(posedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HoldOffCycles) @(posedge clock);
         end else begin
            rsp_tready <= quiet || ($urandom_range(99) >= IdlePercent);
         end
      end
   end

   // response check against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (quadlet_expect_q.size() == 0) begin
            $error("unexpected response quadlet_data %h", rsp_tdata);
            failures++;
         end else begin
            expected_quadlet = quadlet_expect_q.pop_front();
            if (rsp_tdata !== expected_quadlet.data) begin
               $error("quadlet_data (index %0d): expected %h, actual %h",
                      expected_quadlet.index, expected_quadlet.data, rsp_tdata);
               failures++;
            end
         end
      end
   end

   // watchdog on cycles without any request or response moving
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WatchdogLimit) begin
         $display("config_rom_quadlet_generator regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      csr_wr_en  = 1'b0;
      csr_index  = '0;
      csr_wdata  = '0;
      rom_bus_options = '0;
      rom_guid_high   = '0;
      rom_guid_low    = '0;
      rom_root_dir    = 1'b1;
      rom_node_caps   = 1'b1;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed reads under reset defaults
      foreach (directed_rows[r]) begin
         send_read(directed_rows[r].index, directed_rows[r].fixed, directed_rows[r].data);
      end

      for (int phase = 0; phase < PhaseCount; phase++) begin
         case (phase)
            0: apply_settings('1, '1, '1, '1, '1);
            // all zero, bus info block only
            1: apply_settings('0, '0, '0, '0, '0);
            // node caps off through an even wide value
            2: apply_settings($urandom, $urandom, $urandom, 32'h0000_0001, 32'hFFFF_FFFE);
            // root dir off while node caps on
            3: apply_settings($urandom, $urandom, $urandom, 32'hFFFF_FFFE, 32'h0000_0001);
            default: apply_settings($urandom, $urandom, $urandom, $urandom, $urandom);
         endcase
         quiet = (phase == 4);
         if (phase == 0) begin
            hold_off_pending = 1'b1;
         end
         for (int n = 0; n < ReadsPerPhase; n++) begin
            if (phase == 3 && n == ReadsPerPhase / 2) begin
               drain_responses();
            end
            if ($urandom_range(99) < 70) begin
               send_read(8'($urandom_range(9)), 1'b0, '0);
            end else begin
               send_read(8'($urandom_range(255)), 1'b0, '0);
            end
         end
      end

      drain_responses();
      repeat (SettleCycles) @(posedge clock);
      if (failures == 0) begin
         $display("config_rom_quadlet_generator regression: pass");
      end else begin
         $display("config_rom_quadlet_generator regression: fail");
      end
      $finish;
   end

endmodule

/* config_rom_quadlet_generator.f */
sv/crqg_pkg.sv
sv/config_rom_quadlet_generator.sv
sim/testbench.sv
